>>> src/isoth_pkg.sv
// Shared constants, payload types and sequencer states of the isodata threshold block.
`default_nettype none

package isoth_pkg;

  // Histogram sizing: each bin saturates at 2^MaxPixelsLog2.
  localparam int unsigned MaxPixelsLog2 = 20;
  localparam int unsigned PixW          = 8;
  localparam int unsigned NumBins       = 256;
  localparam int unsigned CntW          = MaxPixelsLog2 + 1;
  localparam int unsigned TotW          = CntW + PixW;
  localparam int unsigned SumW          = CntW + 2 * PixW;
  localparam int unsigned QuotW         = PixW;
  localparam int unsigned IterW         = 10;

  localparam logic [CntW-1:0]  BinLimit  = {1'b1, {MaxPixelsLog2{1'b0}}};
  localparam logic [IterW-1:0] IterReset = IterW'(100);
  localparam logic [PixW-1:0]  PixMax    = PixW'(NumBins - 1);

  // One pixel transaction.
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            last;
  } isoth_in_t;

  // One result transaction.
  typedef struct packed {
    logic [PixW-1:0] threshold;
    logic [PixW-1:0] spread;
  } isoth_out_t;

  // Write request into the histogram store.
  typedef struct packed {
    logic            en;
    logic [PixW-1:0] addr;
    logic [CntW-1:0] data;
  } isoth_wr_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_INIT,
    ST_CHECK,
    ST_SWEEP,
    ST_FLUSH,
    ST_DIV_LO,
    ST_WAIT_LO,
    ST_DIV_HI,
    ST_WAIT_HI,
    ST_UPDATE,
    ST_OUT
  } isoth_state_e;

endpackage

`default_nettype wire

>>> src/isoth_hist.sv
// Histogram store: 256 bin counters in a memory with one valid flag per bin.
`default_nettype none

module isoth_hist (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clr_i,
  input  wire isoth_pkg::isoth_wr_t       wr_i,
  input  wire logic [isoth_pkg::PixW-1:0] raddr_i,
  output logic      [isoth_pkg::CntW-1:0] rdata_o
);

  logic [isoth_pkg::CntW-1:0] mem [isoth_pkg::NumBins];
  logic [isoth_pkg::CntW-1:0] mem_rd_q;
  logic [isoth_pkg::NumBins-1:0] valid_q;
  logic rd_valid_q;

  // Memory array: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    mem_rd_q <= mem[raddr_i];
  end

  // Valid flags make a never-written bin read as zero; clearing drops them all at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[raddr_i];
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rd_valid_q ? mem_rd_q : '0;

endmodule

`default_nettype wire

>>> src/isoth_div.sv
// Restoring divider that yields one quotient bit per cycle for an 8-bit class mean.
`default_nettype none

module isoth_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [isoth_pkg::SumW-1:0]  dividend_i,
  input  wire logic [isoth_pkg::TotW-1:0]  divisor_i,
  output logic      [isoth_pkg::QuotW-1:0] quot_o,
  output logic                             done_o
);

  localparam int unsigned StepW = $clog2(isoth_pkg::QuotW);

  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [StepW-1:0]            step_q, step_d;
  logic [isoth_pkg::SumW-1:0]  rem_q, rem_d;
  logic [isoth_pkg::SumW-1:0]  dsh_q, dsh_d;
  logic [isoth_pkg::QuotW-1:0] quot_q, quot_d;
  logic                        fits;

  // One compare and subtract per cycle; the shifted divisor walks right a bit each step.
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    fits   = (rem_q >= dsh_q);
    if (start_i) begin
      run_d  = 1'b1;
      step_d = StepW'(isoth_pkg::QuotW - 1);
      rem_d  = dividend_i;
      dsh_d  = isoth_pkg::SumW'(divisor_i) << (isoth_pkg::QuotW - 1);
      quot_d = '0;
    end else if (run_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[isoth_pkg::QuotW-2:0], fits};
      dsh_d  = dsh_q >> 1;
      step_d = step_q - StepW'(1);
      if (step_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> src/isodata_auto_threshold_core.sv
// Top level of the isodata threshold block: pixel intake, histogram sweep and pass sequencer.
//
// Usage: pixels arrive on in_i with start high; a transaction is taken at a rising edge with
// start high and busy low. While an image streams in, busy stays low, so one pixel can be
// taken every cycle (a bin update is a read then a write, with forwarding between
// back-to-back pixels that hit the same bin).
// The pixel with last set ends the image. busy then rises and the sequencer runs the
// isodata passes. Each pass sweeps the histogram bins from min to max once through one
// shared multiplier, then runs the lower and upper class means through one shared
// 8-step divider (an empty class skips it). At most max_iterations passes run.
// The result is shown on result_o for exactly one cycle with result_valid_o high; the
// receiver cannot hold it off. In that cycle the histogram is cleared and busy falls in
// the next one. A pixel without last gives no result.
// The iteration limit is written through cfg_valid_i and cfg_data_i; cfg_ready_o is
// always high and writes are expected only while the block is idle.
// Reset sets the limit to 100, empties the histogram and readies the block for a new image.
`default_nettype none

module isodata_auto_threshold_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire isoth_pkg::isoth_in_t        in_i,
  output isoth_pkg::isoth_out_t            result_o,
  output logic                             result_valid_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [isoth_pkg::IterW-1:0] cfg_data_i
);

  localparam int unsigned PixW = isoth_pkg::PixW;
  localparam int unsigned CntW = isoth_pkg::CntW;
  localparam int unsigned TotW = isoth_pkg::TotW;
  localparam int unsigned SumW = isoth_pkg::SumW;

  isoth_pkg::isoth_state_e state_q, state_d;

  logic [isoth_pkg::IterW-1:0] iter_max_q;
  logic [PixW-1:0] mn_q, mn_d, mx_q, mx_d;
  logic [PixW-1:0] thr_q, thr_d, next_q, next_d, spread_q, spread_d;
  logic [PixW-1:0] m1_q, m1_d, m2_q, m2_d, idx_q, idx_d;
  logic [isoth_pkg::IterW-1:0] left_q, left_d;

  // Intake pipeline: bin read in flight, then the last write for forwarding.
  logic            s1_vld_q, s1_vld_d;
  logic [PixW-1:0] s1_addr_q, s1_addr_d;
  logic            w_vld_q;
  logic [PixW-1:0] w_addr_q;
  logic [CntW-1:0] w_data_q;

  // Sweep pipeline: read, multiply, accumulate.
  logic            p1_vld_q, p1_vld_d;
  logic [PixW-1:0] p1_idx_q, p1_idx_d;
  logic            p2_vld_q;
  logic            p2_side_q, p2_side_d;
  logic [TotW-1:0] p2_prod_q, p2_prod_d;
  logic [CntW-1:0] p2_cnt_q;
  logic [SumW-1:0] sum_lo_q, sum_lo_d, sum_hi_q, sum_hi_d;
  logic [TotW-1:0] cnt_lo_q, cnt_lo_d, cnt_hi_q, cnt_hi_d;

  logic                   accept;
  logic                   hist_clr;
  isoth_pkg::isoth_wr_t   hist_wr;
  logic [PixW-1:0]        hist_raddr;
  logic [CntW-1:0]        hist_rdata;
  logic [CntW-1:0]        bin_cur;
  logic [CntW-1:0]        bin_inc;
  logic                   div_start;
  logic [SumW-1:0]        div_dividend;
  logic [TotW-1:0]        div_divisor;
  logic [PixW-1:0]        div_quot;
  logic                   div_done;
  logic [PixW:0]          pair_sum;
  logic [PixW:0]          mean_sum;

  assign accept      = start && !busy;
  assign busy        = (state_q != isoth_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Bin increment with saturation; forward the previous write when it hits the same bin.
  assign bin_cur = (w_vld_q && (w_addr_q == s1_addr_q)) ? w_data_q : hist_rdata;
  assign bin_inc = (bin_cur < isoth_pkg::BinLimit) ? (bin_cur + CntW'(1)) : bin_cur;

  assign hist_wr.en   = s1_vld_q;
  assign hist_wr.addr = s1_addr_q;
  assign hist_wr.data = bin_inc;

  assign s1_vld_d  = accept;
  assign s1_addr_d = in_i.pixel;

  // Sweep stages: the read issued in the sweep state lands in the next cycle.
  assign p1_vld_d  = (state_q == isoth_pkg::ST_SWEEP);
  assign p1_idx_d  = idx_q;
  assign p2_prod_d = TotW'(hist_rdata) * TotW'(p1_idx_q);
  assign p2_side_d = (p1_idx_q >= thr_q);

  // The divider serves the lower class first, then the upper class.
  assign div_dividend = (state_q == isoth_pkg::ST_DIV_HI) ? sum_hi_q : sum_lo_q;
  assign div_divisor  = (state_q == isoth_pkg::ST_DIV_HI) ? cnt_hi_q : cnt_lo_q;

  assign pair_sum = {1'b0, mn_q} + {1'b0, mx_q};
  assign mean_sum = {1'b0, m1_q} + {1'b0, m2_q};

  isoth_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (hist_clr),
    .wr_i    (hist_wr),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  isoth_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  // Sequencer: next state, pass bookkeeping and accumulation.
  always_comb begin
    state_d    = state_q;
    mn_d       = mn_q;
    mx_d       = mx_q;
    thr_d      = thr_q;
    next_d     = next_q;
    spread_d   = spread_q;
    m1_d       = m1_q;
    m2_d       = m2_q;
    idx_d      = idx_q;
    left_d     = left_q;
    sum_lo_d   = sum_lo_q;
    sum_hi_d   = sum_hi_q;
    cnt_lo_d   = cnt_lo_q;
    cnt_hi_d   = cnt_hi_q;
    hist_raddr = idx_q;
    hist_clr   = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      isoth_pkg::ST_IDLE: begin
        hist_raddr = in_i.pixel;
        if (accept) begin
          if (in_i.pixel < mn_q) begin
            mn_d = in_i.pixel;
          end
          if (in_i.pixel > mx_q) begin
            mx_d = in_i.pixel;
          end
          if (in_i.last) begin
            state_d = isoth_pkg::ST_DRAIN;
          end
        end
      end
      isoth_pkg::ST_DRAIN: begin
        // The final bin update is written at the end of this cycle.
        state_d = isoth_pkg::ST_INIT;
      end
      isoth_pkg::ST_INIT: begin
        if (mn_q == mx_q) begin
          thr_d    = pair_sum[PixW:1];
          spread_d = '0;
          state_d  = isoth_pkg::ST_OUT;
        end else begin
          thr_d    = '0;
          next_d   = pair_sum[PixW:1];
          spread_d = (mx_q >= mn_q) ? (mx_q - mn_q) : (mn_q - mx_q);
          left_d   = iter_max_q;
          state_d  = isoth_pkg::ST_CHECK;
        end
      end
      isoth_pkg::ST_CHECK: begin
        if ((thr_q != next_q) && (left_q != '0)) begin
          thr_d    = next_q;
          left_d   = left_q - isoth_pkg::IterW'(1);
          idx_d    = mn_q;
          sum_lo_d = '0;
          sum_hi_d = '0;
          cnt_lo_d = '0;
          cnt_hi_d = '0;
          state_d  = isoth_pkg::ST_SWEEP;
        end else begin
          state_d = isoth_pkg::ST_OUT;
        end
      end
      isoth_pkg::ST_SWEEP: begin
        idx_d = idx_q + PixW'(1);
        if (idx_q == mx_q) begin
          state_d = isoth_pkg::ST_FLUSH;
        end
      end
      isoth_pkg::ST_FLUSH: begin
        if (!p1_vld_q && !p2_vld_q) begin
          state_d = isoth_pkg::ST_DIV_LO;
        end
      end
      isoth_pkg::ST_DIV_LO: begin
        // An empty lower class takes the minimum as its mean.
        if (cnt_lo_q == '0) begin
          m1_d    = mn_q;
          state_d = isoth_pkg::ST_DIV_HI;
        end else begin
          div_start = 1'b1;
          state_d   = isoth_pkg::ST_WAIT_LO;
        end
      end
      isoth_pkg::ST_WAIT_LO: begin
        if (div_done) begin
          m1_d    = div_quot;
          state_d = isoth_pkg::ST_DIV_HI;
        end
      end
      isoth_pkg::ST_DIV_HI: begin
        // An empty upper class takes the maximum as its mean.
        if (cnt_hi_q == '0) begin
          m2_d    = mx_q;
          state_d = isoth_pkg::ST_UPDATE;
        end else begin
          div_start = 1'b1;
          state_d   = isoth_pkg::ST_WAIT_HI;
        end
      end
      isoth_pkg::ST_WAIT_HI: begin
        if (div_done) begin
          m2_d    = div_quot;
          state_d = isoth_pkg::ST_UPDATE;
        end
      end
      isoth_pkg::ST_UPDATE: begin
        next_d   = mean_sum[PixW:1];
        spread_d = (m2_q >= m1_q) ? (m2_q - m1_q) : (m1_q - m2_q);
        state_d  = isoth_pkg::ST_CHECK;
      end
      isoth_pkg::ST_OUT: begin
        hist_clr = 1'b1;
        mn_d     = isoth_pkg::PixMax;
        mx_d     = '0;
        state_d  = isoth_pkg::ST_IDLE;
      end
      default: begin
        state_d = isoth_pkg::ST_IDLE;
      end
    endcase
    // Accumulate the weighted bin into its class as it leaves the multiplier.
    if (p2_vld_q) begin
      if (p2_side_q) begin
        sum_hi_d = sum_hi_q + SumW'(p2_prod_q);
        cnt_hi_d = cnt_hi_q + TotW'(p2_cnt_q);
      end else begin
        sum_lo_d = sum_lo_q + SumW'(p2_prod_q);
        cnt_lo_d = cnt_lo_q + TotW'(p2_cnt_q);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= isoth_pkg::ST_IDLE;
      iter_max_q <= isoth_pkg::IterReset;
      mn_q       <= isoth_pkg::PixMax;
      mx_q       <= '0;
      s1_vld_q   <= 1'b0;
      w_vld_q    <= 1'b0;
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      mn_q     <= mn_d;
      mx_q     <= mx_d;
      s1_vld_q <= s1_vld_d;
      w_vld_q  <= s1_vld_q;
      p1_vld_q <= p1_vld_d;
      p2_vld_q <= p1_vld_q;
      if (cfg_valid_i && cfg_ready_o) begin
        iter_max_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    thr_q     <= thr_d;
    next_q    <= next_d;
    spread_q  <= spread_d;
    m1_q      <= m1_d;
    m2_q      <= m2_d;
    idx_q     <= idx_d;
    left_q    <= left_d;
    s1_addr_q <= s1_addr_d;
    w_addr_q  <= s1_addr_q;
    w_data_q  <= bin_inc;
    p1_idx_q  <= p1_idx_d;
    p2_prod_q <= p2_prod_d;
    p2_cnt_q  <= hist_rdata;
    p2_side_q <= p2_side_d;
    sum_lo_q  <= sum_lo_d;
    sum_hi_q  <= sum_hi_d;
    cnt_lo_q  <= cnt_lo_d;
    cnt_hi_q  <= cnt_hi_d;
  end

  // Result transaction: one cycle, straight from registers.
  assign result_valid_o     = (state_q == isoth_pkg::ST_OUT);
  assign result_o.threshold = thr_q;
  assign result_o.spread    = spread_q;

endmodule

`default_nettype wire
